// ===== src/rgb_histogram_frame_diff_macros.svh =====
`ifndef RGB_HISTOGRAM_FRAME_DIFF_MACROS_SVH
`define RGB_HISTOGRAM_FRAME_DIFF_MACROS_SVH

// same-cycle implication on the rising edge of clk, off during reset
`define RHFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on the rising edge of clk, off during reset
`define RHFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rhfd_pkg.sv =====
package rhfd_pkg;

  localparam int BINS_PER_CHANNEL = 6;
  localparam int COUNT_BITS_DEF   = 22;

  localparam int SQ_BITS     = 38;   // squared difference sums
  localparam int FRAC_SHIFT  = 24;   // 12 fractional bits after the root
  localparam int TOTAL_SHIFT = 12;
  localparam int SQ_IN_W     = 62;   // widest root operand
  localparam int SQ_ITERS    = SQ_IN_W / 2;
  localparam int ROOT_W      = SQ_ITERS;
  localparam int NUM_W       = 40;
  localparam int DEN_W       = 39;
  localparam int HIST_GAIN   = 2550;
  localparam int DIFF_GAIN   = 255;
  localparam int SECOND_WT   = 9;
  localparam int BYTE_MAX    = 255;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_PIXEL = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    SEL_COUNT  = 2'd0,
    SEL_SECOND = 2'd1,
    SEL_MAX    = 2'd2
  } sel_t;

  typedef struct packed {
    logic latch;
    logic clear;
    logic mem_rd;
    logic pix_wr;
    logic sq_load;
    logic sq_store;
    logic mul;
    logic div_load;
    logic emit;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic hist;
    logic zero;
    logic sq_done;
    logic div_done;
  } status_t;

endpackage

// ===== src/rhfd_sqrt.sv =====
module rhfd_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [rhfd_pkg::SQ_IN_W-1:0] operand,
  output logic [rhfd_pkg::ROOT_W-1:0]  root,
  output logic                        done
);

  localparam int W     = rhfd_pkg::SQ_IN_W + 1;
  localparam int CNT_W = $clog2(rhfd_pkg::SQ_ITERS + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     res;
  logic [W-1:0]     bitv;
  logic [W-1:0]     trial;
  logic [CNT_W-1:0] cnt;

  assign trial = res + bitv;

  // one result bit per cycle, highest first
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt  <= CNT_W'(rhfd_pkg::SQ_ITERS);
      rem  <= W'(operand);
      res  <= '0;
      bitv <= W'(1) << (2 * (rhfd_pkg::SQ_ITERS - 1));
    end else if (cnt != '0) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt - CNT_W'(1);
    end
  end

  assign root = res[rhfd_pkg::ROOT_W-1:0];
  assign done = (cnt == '0) && !load;

endmodule

// ===== src/rhfd_div.sv =====
module rhfd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [rhfd_pkg::NUM_W-1:0] num,
  input  logic [rhfd_pkg::DEN_W-1:0] den,
  output logic [rhfd_pkg::NUM_W-1:0] quo,
  output logic                       done
);

  localparam int NW    = rhfd_pkg::NUM_W;
  localparam int DW    = rhfd_pkg::DEN_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem;
  logic [NW-1:0]    dvd;
  logic [DW:0]      trial;
  logic [CNT_W-1:0] cnt;

  assign trial = {rem, dvd[NW-1]};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= CNT_W'(NW);
      rem <= '0;
      dvd <= num;
      quo <= '0;
    end else if (cnt != '0) begin
      if (trial >= {1'b0, den}) begin
        rem <= DW'(trial - {1'b0, den});
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
      dvd <= {dvd[NW-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign done = (cnt == '0) && !load;

endmodule

// ===== src/rhfd_dp.sv =====
module rhfd_dp #(
  parameter int COUNT_BITS       = rhfd_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  rhfd_pkg::cmd_t    cmd,
  output rhfd_pkg::status_t st,
  input  logic [1:0]        opcode,
  input  logic              prev_valid,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic [7:0]        prev_red,
  input  logic [7:0]        prev_green,
  input  logic [7:0]        prev_blue,
  input  logic [7:0]        read_position,
  output logic              strobe,
  output logic [7:0]        position,
  output logic [7:0]        value
);

  localparam int N     = rhfd_pkg::BINS_PER_CHANNEL;
  localparam int NN    = N * N;
  localparam int S     = NN * N;
  localparam int IDX_W = $clog2(S);
  localparam int CB    = COUNT_BITS;
  localparam int SB    = rhfd_pkg::SQ_BITS;
  localparam int NW    = rhfd_pkg::NUM_W;
  localparam int DW    = rhfd_pkg::DEN_W;
  localparam int RW    = rhfd_pkg::ROOT_W;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};
  localparam logic [SB-1:0] SMAX = {SB{1'b1}};

  // latched item
  logic [1:0] op_lat;
  logic [7:0] p_lat;
  logic [7:0] cur [3];
  logic [7:0] prv [3];

  // frame state
  logic [CB-1:0] bin_mem [S];
  logic [S-1:0]  bin_valid;
  logic [CB-1:0] max_count;
  logic [CB-1:0] second_count;
  logic [CB-1:0] pixel_total;
  logic [SB-1:0] sums [3];
  logic          have_prev;

  logic [CB-1:0] rd_data;
  logic          rd_valid;
  logic [CB-1:0] cnt_cur;
  logic [CB-1:0] cnt_new;

  // pixel bin index
  logic [3:0]       q [3];
  logic [IDX_W-1:0] pidx;
  logic [IDX_W-1:0] hidx;
  logic [IDX_W-1:0] addr;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q[c] = 4'((12'(cur[c]) * 12'(N)) >> 8);
    end
    pidx = IDX_W'(q[0] * NN + q[1] * N + q[2]);
  end

  // read position to bin: g = p/NN, r = (p/N)%N, b = p%N
  logic [9:0] pw;
  logic [9:0] rem1;
  logic [9:0] rem2;
  logic [3:0] hg;
  logic [3:0] hr;
  logic       kind_hist;
  logic       kind_diff;
  logic [1:0] ch;

  always_comb begin
    pw = {2'b00, p_lat};
    hg = '0;
    for (int k = 1; k < N; k++) begin
      if (pw >= 10'(k * NN)) hg = 4'(k);
    end
    rem1 = pw - 10'(hg * NN);
    hr = '0;
    for (int k = 1; k < N; k++) begin
      if (rem1 >= 10'(k * N)) hr = 4'(k);
    end
    rem2 = rem1 - 10'(hr * N);
    hidx = IDX_W'(hr * NN + hg * N + rem2);
    kind_hist = pw < 10'(S);
    kind_diff = (pw >= 10'(S)) && (pw < 10'(S + 3));
    ch = 2'(pw - 10'(S));
  end

  assign addr    = (op_lat == rhfd_pkg::OP_READ) ? hidx : pidx;
  assign cnt_cur = rd_valid ? rd_data : '0;
  assign cnt_new = (cnt_cur == CMAX) ? cnt_cur : cnt_cur + CB'(1);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_lat <= opcode;
      p_lat  <= read_position;
      cur[0] <= red;
      cur[1] <= green;
      cur[2] <= blue;
      prv[0] <= prev_red;
      prv[1] <= prev_green;
      prv[2] <= prev_blue;
    end
  end

  // bin store, read registered
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_data  <= bin_mem[addr];
      rd_valid <= bin_valid[addr];
    end
    if (cmd.pix_wr) begin
      bin_mem[pidx] <= cnt_new;
    end
  end

  logic [7:0]    dabs [3];
  logic [SB:0]   ssum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dabs[c] = (cur[c] > prv[c]) ? cur[c] - prv[c] : prv[c] - cur[c];
      ssum[c] = (SB + 1)'(sums[c]) + (SB + 1)'(16'(dabs[c]) * 16'(dabs[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      bin_valid    <= '0;
      max_count    <= '0;
      second_count <= '0;
      pixel_total  <= '0;
      for (int c = 0; c < 3; c++) sums[c] <= '0;
    end else if (cmd.pix_wr) begin
      bin_valid[pidx] <= 1'b1;
      if (cnt_new > max_count) begin
        second_count <= max_count;
        max_count    <= cnt_new;
      end
      if (pixel_total != CMAX) pixel_total <= pixel_total + CB'(1);
      if (have_prev) begin
        for (int c = 0; c < 3; c++) begin
          sums[c] <= (ssum[c] > (SB + 1)'(SMAX)) ? SMAX : ssum[c][SB-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (cmd.clear) begin
      have_prev <= prev_valid;
    end
  end

  // square roots, products, quotient
  logic [rhfd_pkg::SQ_IN_W-1:0] sq_op;
  logic [CB-1:0]                hsel;
  logic [RW-1:0]                root;
  logic [RW-1:0]                root_c;
  logic [RW-1:0]                root_2;
  logic [RW-1:0]                root_m;
  logic                         sq_done;
  logic [NW-1:0]                num;
  logic [DW-1:0]                den;
  logic [NW-1:0]                quo;
  logic                         div_done;

  always_comb begin
    case (cmd.sel)
      rhfd_pkg::SEL_SECOND: hsel = second_count;
      rhfd_pkg::SEL_MAX:    hsel = max_count;
      default:              hsel = cnt_cur;
    endcase
    if (kind_hist) begin
      sq_op = rhfd_pkg::SQ_IN_W'({hsel, {rhfd_pkg::FRAC_SHIFT{1'b0}}});
    end else begin
      sq_op = rhfd_pkg::SQ_IN_W'({sums[ch], {rhfd_pkg::FRAC_SHIFT{1'b0}}});
    end
  end

  rhfd_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .load    (cmd.sq_load),
    .operand (sq_op),
    .root    (root),
    .done    (sq_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.sq_store) begin
      case (cmd.sel)
        rhfd_pkg::SEL_SECOND: root_2 <= root;
        rhfd_pkg::SEL_MAX:    root_m <= root;
        default:              root_c <= root;
      endcase
    end
    if (cmd.mul) begin
      if (kind_hist) begin
        num <= NW'(root_c) * NW'(rhfd_pkg::HIST_GAIN);
        den <= DW'(root_2) * DW'(rhfd_pkg::SECOND_WT) + DW'(root_m);
      end else begin
        num <= NW'(root_c) * NW'(rhfd_pkg::DIFF_GAIN);
        den <= DW'({pixel_total, {rhfd_pkg::TOTAL_SHIFT{1'b0}}});
      end
    end
  end

  rhfd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .load (cmd.div_load),
    .num  (num),
    .den  (den),
    .quo  (quo),
    .done (div_done)
  );

  logic zero;

  assign zero = kind_hist ? (max_count == '0) :
                kind_diff ? (!have_prev || pixel_total == '0) : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
    if (cmd.emit) begin
      position <= p_lat;
      if (zero) begin
        value <= '0;
      end else if (quo > NW'(rhfd_pkg::BYTE_MAX)) begin
        value <= 8'(rhfd_pkg::BYTE_MAX);
      end else begin
        value <= quo[7:0];
      end
    end
  end

  assign st.hist     = kind_hist;
  assign st.zero     = zero;
  assign st.sq_done  = sq_done;
  assign st.div_done = div_done;

endmodule

// ===== src/rhfd_ctrl.sv =====
module rhfd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        opcode,
  input  rhfd_pkg::status_t st,
  output rhfd_pkg::cmd_t    cmd,
  output logic              busy
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_PIX_RD   = 10'b00_0000_0010,
    S_PIX_WR   = 10'b00_0000_0100,
    S_RD_MEM   = 10'b00_0000_1000,
    S_SQ_LOAD  = 10'b00_0001_0000,
    S_SQ_RUN   = 10'b00_0010_0000,
    S_MUL      = 10'b00_0100_0000,
    S_DIV_LOAD = 10'b00_1000_0000,
    S_DIV_RUN  = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t         state;
  state_t         state_next;
  rhfd_pkg::sel_t sel;
  rhfd_pkg::sel_t sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= rhfd_pkg::SEL_COUNT;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.sel    = sel;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          if (opcode == rhfd_pkg::OP_START) begin
            cmd.clear = 1'b1;
          end else if (opcode == rhfd_pkg::OP_PIXEL) begin
            state_next = S_PIX_RD;
          end else if (opcode == rhfd_pkg::OP_READ) begin
            state_next = S_RD_MEM;
          end
        end
      end
      S_PIX_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_PIX_WR;
      end
      S_PIX_WR: begin
        cmd.pix_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_RD_MEM: begin
        cmd.mem_rd = 1'b1;
        sel_next   = rhfd_pkg::SEL_COUNT;
        state_next = st.zero ? S_DONE : S_SQ_LOAD;
      end
      S_SQ_LOAD: begin
        cmd.sq_load = 1'b1;
        state_next  = S_SQ_RUN;
      end
      S_SQ_RUN: begin
        if (st.sq_done) begin
          cmd.sq_store = 1'b1;
          if (st.hist && sel != rhfd_pkg::SEL_MAX) begin
            sel_next   = rhfd_pkg::sel_t'(sel + 2'd1);
            state_next = S_SQ_LOAD;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (st.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== src/rgb_histogram_frame_diff.sv =====
// channel   ports                                              transaction
// input     start, busy, opcode, prev_valid, pixel, read_pos   start && !busy
// result    strobe, position, value                            strobe, one cycle
//
// start frame: busy stays low; pixel: busy through the bin read and the bin update
// read: for a histogram position, three roots of 31 result bits each and a divide with a
// 40-bit quotient; for a difference position, one root and the divide; neither when zero
// the result strobe rises the cycle busy falls; the receiver cannot stall it
// rst is synchronous, active high; it empties the histogram and drops the previous frame
module rgb_histogram_frame_diff #(
  parameter int COUNT_BITS       = rhfd_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic       prev_valid,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] prev_red,
  input  logic [7:0] prev_green,
  input  logic [7:0] prev_blue,
  input  logic [7:0] read_position,
  output logic       strobe,
  output logic [7:0] position,
  output logic [7:0] value
);

  // controller to datapath commands and status
  rhfd_pkg::cmd_t    cmd;
  rhfd_pkg::status_t st;
  logic              accept;

  // a transaction is taken only while the controller sits idle
  assign accept = start && !busy;

  rhfd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .opcode (opcode),
    .st     (st),
    .cmd    (cmd),
    .busy   (busy)
  );

  // bin store with valid bits, running max, diff sums, root and divide units
  rhfd_dp #(
    .COUNT_BITS       (COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .opcode        (opcode),
    .prev_valid    (prev_valid),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .prev_red      (prev_red),
    .prev_green    (prev_green),
    .prev_blue     (prev_blue),
    .read_position (read_position),
    .strobe        (strobe),
    .position      (position),
    .value         (value)
  );

endmodule

// ===== src/rhfd_checker.sv =====
`include "rgb_histogram_frame_diff_macros.svh"

module rhfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] opcode,
  input logic       strobe
);

  `RHFD_ASSERT_NEXT(a_strobe_single, clk, rst, strobe, !strobe, "result strobe held")
  `RHFD_ASSERT_NOW(a_strobe_after_work, clk, rst, strobe, $past(busy), "result without work")
  `RHFD_ASSERT_NEXT(a_read_busy, clk, rst, start && !busy && opcode == rhfd_pkg::OP_READ, busy, "read not taken")
  `RHFD_ASSERT_NEXT(a_start_quick, clk, rst, start && !busy && opcode == rhfd_pkg::OP_START, !busy, "start stalls")

endmodule

bind rgb_histogram_frame_diff rhfd_checker u_rhfd_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .opcode (opcode),
  .strobe (strobe)
);

// ===== test/tb_rgb_histogram_frame_diff.sv =====
`timescale 1ns / 100ps

module tb_rgb_histogram_frame_diff;

  localparam int N         = rhfd_pkg::BINS_PER_CHANNEL;
  localparam int SLOTS     = N * N * N;
  localparam int CNT_W     = rhfd_pkg::COUNT_BITS_DEF;
  localparam longint unsigned CNT_SAT = (64'd1 << CNT_W) - 1;
  localparam longint unsigned SQ_SAT  = (64'd1 << 38) - 1;
  localparam int IDLE_LIMIT = 5000;   // cycles with no transaction before giving up
  localparam int DRAIN_WAIT = 300;

  // one pending input transaction
  typedef struct {
    logic [1:0] op;
    logic       pv;
    logic [7:0] r, g, b, pr, pg, pb;
    logic [7:0] pos;
  } cmd_item_t;

  typedef struct {
    logic [7:0] pos;
    logic [7:0] val;
  } read_result_t;

  logic       clk, rst, start, busy, prev_valid, strobe;
  logic [1:0] opcode;
  logic [7:0] red, green, blue, prev_red, prev_green, prev_blue, read_position;
  logic [7:0] position, value;

  rgb_histogram_frame_diff DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .prev_valid(prev_valid), .red(red), .green(green), .blue(blue),
    .prev_red(prev_red), .prev_green(prev_green), .prev_blue(prev_blue),
    .read_position(read_position), .strobe(strobe), .position(position),
    .value(value)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // shadow copy of the histogram and difference state
  longint unsigned hist_bins[SLOTS];
  longint unsigned peak_cnt, runner_cnt, pix_cnt;
  longint unsigned sqdiff[3];
  bit              prev_frame;

  cmd_item_t    pending_cmds[$];
  read_result_t expected_reads[$];
  int  mismatches, reads_seen, accepted, idle_cycles;
  int  sent_count;
  bit  hold_sender, quiet_stretch;
  bit  taken;   // set by the monitor when the last rising edge took a transaction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned quant_level(logic [7:0] c);
    return (int'(c) * N) >> 8;
  endfunction

  function automatic void clear_frame_state();
    foreach (hist_bins[i]) hist_bins[i] = 0;
    peak_cnt = 0;
    runner_cnt = 0;
    pix_cnt = 0;
    foreach (sqdiff[i]) sqdiff[i] = 0;
  endfunction

  function automatic void ref_reset_shadow();
    clear_frame_state();
    prev_frame = 1'b0;
  endfunction

  function automatic longint unsigned sq_step(longint unsigned acc, logic [7:0] a,
                                              logic [7:0] b);
    longint unsigned d, s;
    d = (a > b) ? a - b : b - a;
    s = acc + d * d;
    return (s > SQ_SAT) ? SQ_SAT : s;
  endfunction

  // normalized byte for one read position, from the current shadow state
  function automatic logic [7:0] read_byte(int unsigned p);
    int unsigned gi, ri, bi, idx;
    longint unsigned sc, s2, sm, den, v, sd;
    v = 0;
    if (p < SLOTS) begin
      gi = p / (N * N);
      ri = (p / N) % N;
      bi = p % N;
      idx = ri * N * N + gi * N + bi;
      if (peak_cnt != 0) begin
        sc = int_sqrt(hist_bins[idx] << 24);
        s2 = int_sqrt(runner_cnt << 24);
        sm = int_sqrt(peak_cnt << 24);
        den = 9 * s2 + sm;
        if (den != 0) v = (2550 * sc) / den;
      end
    end else if (p - SLOTS < 3) begin
      if (prev_frame && pix_cnt != 0) begin
        sd = int_sqrt(sqdiff[p - SLOTS] << 24);
        v = (255 * sd) / (pix_cnt << 12);
      end
    end
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // apply one accepted transaction to the shadow state, queue any read result
  function automatic void predict_cmd(cmd_item_t c);
    int unsigned idx;
    read_result_t rr;
    case (c.op)
      rhfd_pkg::OP_START: begin
        clear_frame_state();
        prev_frame = c.pv;
      end
      rhfd_pkg::OP_PIXEL: begin
        idx = quant_level(c.r) * N * N + quant_level(c.g) * N + quant_level(c.b);
        if (hist_bins[idx] < CNT_SAT) hist_bins[idx]++;
        if (hist_bins[idx] > peak_cnt) begin
          runner_cnt = peak_cnt;
          peak_cnt = hist_bins[idx];
        end
        if (pix_cnt < CNT_SAT) pix_cnt++;
        if (prev_frame) begin
          sqdiff[0] = sq_step(sqdiff[0], c.r, c.pr);
          sqdiff[1] = sq_step(sqdiff[1], c.g, c.pg);
          sqdiff[2] = sq_step(sqdiff[2], c.b, c.pb);
        end
      end
      rhfd_pkg::OP_READ: begin
        rr.pos = c.pos;
        rr.val = read_byte(c.pos);
        expected_reads.push_back(rr);
      end
      default: ;  // opcode 3 does nothing
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // item builders
  function automatic cmd_item_t mk_start(bit pv);
    cmd_item_t c;
    c = '{op: rhfd_pkg::OP_START, pv: pv, default: '0};
    c.pos = 8'($urandom); c.r = 8'($urandom);
    return c;
  endfunction

  function automatic cmd_item_t mk_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic [7:0] pr, logic [7:0] pg, logic [7:0] pb);
    cmd_item_t c;
    c.op = rhfd_pkg::OP_PIXEL; c.pv = 1'($urandom); c.pos = 8'($urandom);
    c.r = r; c.g = g; c.b = b; c.pr = pr; c.pg = pg; c.pb = pb;
    return c;
  endfunction

  function automatic cmd_item_t mk_read(logic [7:0] p);
    cmd_item_t c;
    c = '{op: rhfd_pkg::OP_READ, pv: 1'b0, default: '0};
    c.pos = p; c.pv = 1'($urandom); c.g = 8'($urandom);
    return c;
  endfunction

  function automatic cmd_item_t rand_pixel();
    return mk_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // driver: presents queued transactions on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      // nothing presented, or the last rising edge took what was presented
      if (pending_cmds.size() != 0 && !hold_sender &&
          (quiet_stretch || $urandom_range(99) >= 35)) begin
        start <= 1'b1;
        opcode <= pending_cmds[0].op; prev_valid <= pending_cmds[0].pv;
        red <= pending_cmds[0].r; green <= pending_cmds[0].g; blue <= pending_cmds[0].b;
        prev_red <= pending_cmds[0].pr; prev_green <= pending_cmds[0].pg;
        prev_blue <= pending_cmds[0].pb; read_position <= pending_cmds[0].pos;
        void'(pending_cmds.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predicts on accepted commands, checks strobed results
  always @(posedge clk) begin
    if (rst) begin
      taken = 1'b0;
    end else begin
      if (strobe) begin
        reads_seen++;
        if (expected_reads.size() == 0) begin
          report_mismatch("unexpected result, position", position, 0);
        end else begin
          if (position !== expected_reads[0].pos)
            report_mismatch("position", position, expected_reads[0].pos);
          if (value !== expected_reads[0].val)
            report_mismatch("value", value, expected_reads[0].val);
          void'(expected_reads.pop_front());
        end
      end
      taken = start && !busy;
      if (taken) begin
        predict_cmd('{op: opcode, pv: prev_valid, r: red, g: green, b: blue,
                      pr: prev_red, pg: prev_green, pb: prev_blue, pos: read_position});
        accepted++;
      end
      if (strobe || taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // a well-formed frame: start, a burst of pixels, then reads
  task automatic queue_frame(int npix, int nreads);
    cmd_item_t c;
    bit biased;
    pending_cmds.push_back(mk_start(1'($urandom)));
    biased = 1'($urandom_range(1));
    for (int i = 0; i < npix; i++) begin
      c = rand_pixel();
      if (biased && $urandom_range(3) != 0) begin
        // concentrate on a few colors so max and second max move
        c.r = {1'($urandom_range(1)), 7'h40}; c.g = 8'h80;
        c.b = $urandom_range(1) ? 8'hff : 8'h00;
      end
      pending_cmds.push_back(c);
    end
    for (int i = 0; i < nreads; i++)
      pending_cmds.push_back(mk_read(8'($urandom_range(3) == 0 ?
                                        $urandom_range(SLOTS + 2, SLOTS - 4) :
                                        $urandom_range(255))));
  endtask

  initial begin
    cmd_item_t c;
    rst = 1'b1; start = 1'b0; opcode = rhfd_pkg::OP_START; prev_valid = 1'b0;
    red = '0; green = '0; blue = '0; prev_red = '0; prev_green = '0; prev_blue = '0;
    read_position = '0;
    hold_sender = 1'b0; quiet_stretch = 1'b0; taken = 1'b0;
    mismatches = 0; reads_seen = 0; accepted = 0; idle_cycles = 0;
    ref_reset_shadow();
    repeat (12) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed: empty reads, pixel before any start, extremes, unused opcode
    pending_cmds.push_back(mk_read(8'd0));
    pending_cmds.push_back(mk_read(8'd216));
    pending_cmds.push_back(mk_pixel(8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff));
    pending_cmds.push_back(mk_read(8'd0));
    pending_cmds.push_back(mk_read(8'd217));
    pending_cmds.push_back(mk_start(1'b1));
    pending_cmds.push_back(mk_read(8'd218));   // previous frame but no pixels
    pending_cmds.push_back(mk_pixel(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00));
    pending_cmds.push_back(mk_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h55));
    pending_cmds.push_back(mk_pixel(8'h2a, 8'h2b, 8'haa, 8'h00, 8'hff, 8'hab));
    c = rand_pixel(); c.op = 2'd3;
    pending_cmds.push_back(c);
    c = mk_read(8'd5); c.op = 2'd3;
    pending_cmds.push_back(c);
    pending_cmds.push_back(mk_read(8'd215));
    pending_cmds.push_back(mk_read(8'd0));
    pending_cmds.push_back(mk_read(8'd216));
    pending_cmds.push_back(mk_read(8'd217));
    pending_cmds.push_back(mk_read(8'd218));
    pending_cmds.push_back(mk_read(8'd219));   // past the difference slots
    pending_cmds.push_back(mk_read(8'd255));
    pending_cmds.push_back(mk_start(1'b0));
    pending_cmds.push_back(mk_pixel(8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00));
    pending_cmds.push_back(mk_read(8'd216));   // no previous frame
    pending_cmds.push_back(mk_read(8'd129));

    // pause the sender until every expected result has arrived
    wait (pending_cmds.size() == 0 && !start);
    hold_sender = 1'b1;
    wait (expected_reads.size() == 0);
    hold_sender = 1'b0;

    // random: mostly well-formed frames, some noise
    sent_count = 23;
    while (sent_count < 1200) begin
      if ($urandom_range(9) == 0) begin
        c = rand_pixel();
        c.op = 2'($urandom);
        c.pos = 8'($urandom);
        pending_cmds.push_back(c);
        sent_count++;
      end else begin
        int np, nr;
        np = $urandom_range(4) == 0 ? $urandom_range(120, 40) : $urandom_range(20);
        nr = $urandom_range(6, 1);
        queue_frame(np, nr);
        sent_count += 1 + np + nr;
      end
      // a stretch with no idling in the middle of the run
      quiet_stretch = (sent_count > 500 && sent_count < 700);
      wait (pending_cmds.size() < 40);
    end
    quiet_stretch = 1'b0;

    wait (pending_cmds.size() == 0 && !start);
    wait (expected_reads.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d transactions, %0d read results checked", accepted, reads_seen);
    $display("frames with and without previous frame, all read positions and opcode 3");
    if (mismatches == 0 && expected_reads.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
